/* src/gl_trav_pkg.sv */
`timescale 1ns / 1ps

package gl_trav_pkg;

    // fixed field widths
    localparam int ID_W    = 16;
    localparam int COORD_W = 15;
    localparam int CFG_W   = 6;
    localparam int COL_W   = 5;
    localparam int IDX_W   = 10;

    // configuration port
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 1'd1;
    localparam logic [CFG_W-1:0]     GRID_SIZE_RESET  = 6'd32;

    // result run limit
    localparam int RESULT_CAP = 63;
    localparam int CNT_W      = $clog2(RESULT_CAP);

    // parameter defaults
    localparam int CELL_SHIFT_DEF    = 6;
    localparam int FRAC_BITS_DEF     = 4;
    localparam int MAX_GRID_SIDE_DEF = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_INIT,
        ST_RUN
    } gl_state_t;

    typedef struct packed {
        logic load;
        logic setup;
        logic init;
        logic step;
    } gl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic last;
    } gl_status_t;

endpackage

/* src/gl_trav_ctrl.sv */
`timescale 1ns / 1ps

module gl_trav_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  gl_trav_pkg::gl_status_t status,
    output gl_trav_pkg::gl_cmd_t    cmd
);

    gl_trav_pkg::gl_state_t state_reg;
    gl_trav_pkg::gl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gl_trav_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            gl_trav_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = gl_trav_pkg::ST_SETUP;
                end
            end
            gl_trav_pkg::ST_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = gl_trav_pkg::ST_INIT;
            end
            gl_trav_pkg::ST_INIT: begin
                cmd.init   = 1'b1;
                state_next = gl_trav_pkg::ST_RUN;
            end
            gl_trav_pkg::ST_RUN: begin
                if (status.out_free) begin
                    cmd.step = 1'b1;
                    if (status.last) begin
                        state_next = gl_trav_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = gl_trav_pkg::ST_IDLE;
            end
        endcase
    end

    a_load_then_setup: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> cmd.setup)
        else $error("setup did not follow a load");

    a_setup_then_init: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.setup |=> cmd.init)
        else $error("init did not follow setup");

endmodule

/* src/gl_trav_dpath.sv */
`timescale 1ns / 1ps

module gl_trav_dpath #(
    parameter int CELL_SHIFT    = gl_trav_pkg::CELL_SHIFT_DEF,
    parameter int FRAC_BITS     = gl_trav_pkg::FRAC_BITS_DEF,
    parameter int MAX_GRID_SIDE = gl_trav_pkg::MAX_GRID_SIDE_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [gl_trav_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gl_trav_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic [gl_trav_pkg::ID_W-1:0]        s_line_id,
    input  logic [gl_trav_pkg::COORD_W-1:0]     s_start_x,
    input  logic [gl_trav_pkg::COORD_W-1:0]     s_start_y,
    input  logic [gl_trav_pkg::COORD_W-1:0]     s_end_x,
    input  logic [gl_trav_pkg::COORD_W-1:0]     s_end_y,
    input  gl_trav_pkg::gl_cmd_t                cmd,
    output gl_trav_pkg::gl_status_t             status,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [gl_trav_pkg::ID_W-1:0]        m_line_tag,
    output logic [gl_trav_pkg::COL_W-1:0]       m_cell_column,
    output logic [gl_trav_pkg::COL_W-1:0]       m_cell_row,
    output logic [gl_trav_pkg::IDX_W-1:0]       m_cell_index,
    output logic                                m_out_of_grid,
    output logic                                m_last_cell
);

    localparam int COORD_W   = gl_trav_pkg::COORD_W;
    localparam int CFG_W     = gl_trav_pkg::CFG_W;
    localparam int COL_W     = gl_trav_pkg::COL_W;
    localparam int IDX_W     = gl_trav_pkg::IDX_W;
    localparam int CNT_W     = gl_trav_pkg::CNT_W;
    localparam int POS_SHIFT = FRAC_BITS + CELL_SHIFT;
    localparam int CELL_W    = (POS_SHIFT >= COORD_W) ? 1 : COORD_W - POS_SHIFT;
    localparam int XY_W      = CELL_W + 1;
    localparam int N_W       = CELL_W + 1;
    localparam int EXT_W     = COORD_W + POS_SHIFT + 1;
    localparam int DIST_W    = POS_SHIFT + 1;
    localparam int PROD_W    = DIST_W + COORD_W;
    localparam int ERR_W     = POS_SHIFT + COORD_W + 3;
    localparam int WIDE_W    = (CELL_W + 7 > IDX_W) ? CELL_W + 7 : IDX_W;
    localparam int COLX_W    = (XY_W > COL_W) ? XY_W : COL_W;
    localparam logic [DIST_W-1:0] UNIT = (DIST_W)'(1) << POS_SHIFT;
    localparam logic [CFG_W-1:0]  SIDE_MAX = CFG_W'(MAX_GRID_SIDE);
    localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(gl_trav_pkg::RESULT_CAP - 1);

    // configuration
    logic [CFG_W-1:0] cols_reg;
    logic [CFG_W-1:0] rows_reg;
    logic [CFG_W-1:0] eff_cols;
    logic [CFG_W-1:0] eff_rows;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg <= gl_trav_pkg::GRID_SIZE_RESET;
            rows_reg <= gl_trav_pkg::GRID_SIZE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                gl_trav_pkg::REG_GRID_COLUMNS: cols_reg <= cfg_wdata;
                gl_trav_pkg::REG_GRID_ROWS:    rows_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign eff_cols = (cols_reg > SIDE_MAX) ? SIDE_MAX : cols_reg;
    assign eff_rows = (rows_reg > SIDE_MAX) ? SIDE_MAX : rows_reg;

    // captured segment
    logic [gl_trav_pkg::ID_W-1:0] tag_reg;
    logic [COORD_W-1:0]           ax_reg, ay_reg, bx_reg, by_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            tag_reg <= s_line_id;
            ax_reg  <= s_start_x;
            ay_reg  <= s_start_y;
            bx_reg  <= s_end_x;
            by_reg  <= s_end_y;
        end
    end

    // setup: cells, deltas, distances to the first crossing, products
    logic [EXT_W-1:0]   ax_ext, ay_ext, bx_ext, by_ext;
    logic [EXT_W-1:0]   ax_cell_full, ay_cell_full, bx_cell_full, by_cell_full;
    logic [EXT_W-1:0]   ax_frac_full, ay_frac_full;
    logic [CELL_W-1:0]  ax_cell, ay_cell, bx_cell, by_cell;
    logic [DIST_W-1:0]  ax_frac, ay_frac, dist_x, dist_y;
    logic               xpos, ypos;
    logic [COORD_W-1:0] dx, dy;
    logic [CELL_W-1:0]  span_x, span_y;

    always_comb begin
        ax_ext       = EXT_W'(ax_reg);
        ay_ext       = EXT_W'(ay_reg);
        bx_ext       = EXT_W'(bx_reg);
        by_ext       = EXT_W'(by_reg);
        ax_cell_full = ax_ext >> POS_SHIFT;
        ay_cell_full = ay_ext >> POS_SHIFT;
        bx_cell_full = bx_ext >> POS_SHIFT;
        by_cell_full = by_ext >> POS_SHIFT;
        ax_frac_full = ax_ext - (ax_cell_full << POS_SHIFT);
        ay_frac_full = ay_ext - (ay_cell_full << POS_SHIFT);
        ax_cell      = ax_cell_full[CELL_W-1:0];
        ay_cell      = ay_cell_full[CELL_W-1:0];
        bx_cell      = bx_cell_full[CELL_W-1:0];
        by_cell      = by_cell_full[CELL_W-1:0];
        ax_frac      = ax_frac_full[DIST_W-1:0];
        ay_frac      = ay_frac_full[DIST_W-1:0];
        xpos         = bx_reg > ax_reg;
        ypos         = by_reg > ay_reg;
        dx           = xpos ? bx_reg - ax_reg : ax_reg - bx_reg;
        dy           = ypos ? by_reg - ay_reg : ay_reg - by_reg;
        dist_x       = xpos ? UNIT - ax_frac : ax_frac;
        dist_y       = ypos ? UNIT - ay_frac : ay_frac;
        span_x       = xpos ? bx_cell - ax_cell : ax_cell - bx_cell;
        span_y       = ypos ? by_cell - ay_cell : ay_cell - by_cell;
    end

    logic [XY_W-1:0]    x_reg, x_next, y_reg, y_next;
    logic [COORD_W-1:0] dx_reg, dy_reg;
    logic               xpos_reg, ypos_reg, only_x_reg, only_y_reg;
    logic [PROD_W-1:0]  prodx_reg, prody_reg;
    logic [N_W-1:0]     n_reg, n_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic signed [ERR_W-1:0] err_reg, err_next;

    always_ff @(posedge aclk) begin
        if (cmd.setup) begin
            dx_reg     <= dx;
            dy_reg     <= dy;
            xpos_reg   <= xpos;
            ypos_reg   <= ypos;
            only_x_reg <= (dy == '0);
            only_y_reg <= (dx == '0) && (dy != '0);
            prodx_reg  <= PROD_W'(dist_x) * PROD_W'(dy);
            prody_reg  <= PROD_W'(dist_y) * PROD_W'(dx);
        end
    end

    // stepping unit: one cell per beat
    logic step_y;

    always_comb begin
        step_y   = !only_x_reg && (only_y_reg || (!err_reg[ERR_W-1] && err_reg != '0));
        x_next   = x_reg;
        y_next   = y_reg;
        err_next = err_reg;
        n_next   = n_reg;
        cnt_next = cnt_reg;
        if (cmd.setup) begin
            x_next = XY_W'(ax_cell);
            y_next = XY_W'(ay_cell);
            n_next = N_W'(1) + N_W'(span_x) + N_W'(span_y);
        end else if (cmd.init) begin
            err_next = $signed(ERR_W'(prodx_reg)) - $signed(ERR_W'(prody_reg));
            cnt_next = '0;
        end else if (cmd.step) begin
            if (step_y) begin
                y_next   = ypos_reg ? y_reg + 1'b1 : y_reg - 1'b1;
                err_next = err_reg - $signed(ERR_W'(dx_reg) << POS_SHIFT);
            end else begin
                x_next   = xpos_reg ? x_reg + 1'b1 : x_reg - 1'b1;
                err_next = err_reg + $signed(ERR_W'(dy_reg) << POS_SHIFT);
            end
            n_next   = n_reg - 1'b1;
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        err_reg <= err_next;
        n_reg   <= n_next;
        cnt_reg <= cnt_next;
    end

    // result for the current cell
    logic [WIDE_W-1:0] x_wide, y_wide, idx_wide;
    logic [COLX_W-1:0] x_colx, y_colx;
    logic              oog, is_last;

    always_comb begin
        x_wide   = WIDE_W'(x_reg);
        y_wide   = WIDE_W'(y_reg);
        x_colx   = COLX_W'(x_reg);
        y_colx   = COLX_W'(y_reg);
        // a run ending on a cell edge while moving left can reach column -1
        oog      = x_reg[XY_W-1] || y_reg[XY_W-1] ||
                   (x_wide >= WIDE_W'(eff_cols)) || (y_wide >= WIDE_W'(eff_rows));
        idx_wide = y_wide * WIDE_W'(eff_cols) + x_wide;
        is_last  = (n_reg == N_W'(1)) || (cnt_reg == CNT_LAST);
    end

    // output register
    logic                         m_valid_reg, m_valid_next;
    logic [gl_trav_pkg::ID_W-1:0] tag_out_reg;
    logic [COL_W-1:0]             col_out_reg, row_out_reg;
    logic [IDX_W-1:0]             idx_out_reg;
    logic                         oog_out_reg, last_out_reg;

    assign status.out_free = !m_valid_reg || m_ready;
    assign status.last     = is_last;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.step) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step) begin
            tag_out_reg  <= tag_reg;
            col_out_reg  <= x_colx[COL_W-1:0];
            row_out_reg  <= y_colx[COL_W-1:0];
            idx_out_reg  <= oog ? '0 : idx_wide[IDX_W-1:0];
            oog_out_reg  <= oog;
            last_out_reg <= is_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_line_tag    = tag_out_reg;
    assign m_cell_column = col_out_reg;
    assign m_cell_row    = row_out_reg;
    assign m_cell_index  = idx_out_reg;
    assign m_out_of_grid = oog_out_reg;
    assign m_last_cell   = last_out_reg;

    a_step_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> (!m_valid_reg || m_ready))
        else $error("cell stepped while output beat still waiting");

    a_step_has_cells: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> (n_reg != '0))
        else $error("cell stepped past end of run");

endmodule

/* src/grid_line_cell_traversal.sv */
`timescale 1ns / 1ps

// Walks one line segment (unsigned Q11.4 endpoints) across a square cell grid
// and sends out every cell it touches, start cell first, one beat per cell,
// with last_cell set on the final beat. A segment passes through capture,
// cell/delta/product setup and error init, then visits its cells (at most 63)
// in the single error-stepping unit, stalling while an output beat waits. The
// next segment is taken as soon as the final cell is in the output
// register. grid_columns and grid_rows (cfg index 0 and 1) may only be written
// while idle; values above MAX_GRID_SIDE saturate, and cells outside the grid
// come out with out_of_grid set and cell_index zero.
module grid_line_cell_traversal #(
    parameter int CELL_SHIFT    = gl_trav_pkg::CELL_SHIFT_DEF,
    parameter int FRAC_BITS     = gl_trav_pkg::FRAC_BITS_DEF,
    parameter int MAX_GRID_SIDE = gl_trav_pkg::MAX_GRID_SIDE_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [gl_trav_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gl_trav_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [gl_trav_pkg::ID_W-1:0]      s_line_id,
    input  logic [gl_trav_pkg::COORD_W-1:0]   s_start_x,
    input  logic [gl_trav_pkg::COORD_W-1:0]   s_start_y,
    input  logic [gl_trav_pkg::COORD_W-1:0]   s_end_x,
    input  logic [gl_trav_pkg::COORD_W-1:0]   s_end_y,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [gl_trav_pkg::ID_W-1:0]      m_line_tag,
    output logic [gl_trav_pkg::COL_W-1:0]     m_cell_column,
    output logic [gl_trav_pkg::COL_W-1:0]     m_cell_row,
    output logic [gl_trav_pkg::IDX_W-1:0]     m_cell_index,
    output logic                              m_out_of_grid,
    output logic                              m_last_cell
);

    gl_trav_pkg::gl_cmd_t    cmd;
    gl_trav_pkg::gl_status_t status;

    gl_trav_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    gl_trav_dpath #(
        .CELL_SHIFT    (CELL_SHIFT),
        .FRAC_BITS     (FRAC_BITS),
        .MAX_GRID_SIDE (MAX_GRID_SIDE)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_line_id     (s_line_id),
        .s_start_x     (s_start_x),
        .s_start_y     (s_start_y),
        .s_end_x       (s_end_x),
        .s_end_y       (s_end_y),
        .cmd           (cmd),
        .status        (status),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_line_tag    (m_line_tag),
        .m_cell_column (m_cell_column),
        .m_cell_row    (m_cell_row),
        .m_cell_index  (m_cell_index),
        .m_out_of_grid (m_out_of_grid),
        .m_last_cell   (m_last_cell)
    );

endmodule
